### src/multilevel_priority_job_scheduler_core_macros.svh
// Assertion macros for the job scheduler RTL.
`ifndef MULTILEVEL_PRIORITY_JOB_SCHEDULER_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_JOB_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MLPJS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MLPJS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MLPJS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MLPJS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### src/mlpjs_pkg.sv
// Shared types and codes of the job scheduler.
`default_nettype none
package mlpjs_pkg;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ENQ    = 2'd1,
		CMD_DEQ    = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_ENQUEUED = 3'd1,
		ST_FULL     = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_AGING  = 2'd0,
		CFG_SLICE0 = 2'd1,
		CFG_SLICE1 = 2'd2,
		CFG_SLICE2 = 2'd3
	} cfg_idx_t;

	typedef enum logic [6:0] {
		SQ_IDLE = 7'b0000001,
		SQ_AGE  = 7'b0000010,
		SQ_PRO1 = 7'b0000100,
		SQ_PRO2 = 7'b0001000,
		SQ_OP   = 7'b0010000,
		SQ_PICK = 7'b0100000,
		SQ_FIN  = 7'b1000000
	} seq_t;

	typedef enum logic [1:0] {
		PUSH_PROMOTE = 2'd0,
		PUSH_LOAD    = 2'd1,
		PUSH_REQUEUE = 2'd2
	} push_kind_t;

	typedef struct packed {
		logic       age_en;
		logic       push_en;
		push_kind_t kind;
		logic [1:0] load_level;
	} cell_ctl_t;

	localparam logic [7:0] AGING_RST  = 8'd10;
	localparam logic [3:0] SLICE0_RST = 4'd1;
	localparam logic [3:0] SLICE1_RST = 4'd2;
	localparam logic [3:0] SLICE2_RST = 4'd5;

endpackage
`default_nettype wire

### src/mlpjs_cell.sv
// One job slot cell: job fields plus its row of the queue age matrix.
`default_nettype none
module mlpjs_cell import mlpjs_pkg::*; #(
	parameter int N       = 16,
	parameter int ID_BITS = 16,
	parameter int IDX     = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [ID_BITS-1:0] load_id,
	input  logic               is_active,
	input  logic [N-1:0]       push_vec,
	input  logic               clr_valid,
	input  logic               clr_wait,
	output logic               valid,
	output logic [ID_BITS-1:0] ident,
	output logic [1:0]         base_level,
	output logic [1:0]         level,
	output logic [7:0]         wait_cnt,
	output logic [N-1:0]       older
);

	localparam logic [N-1:0] SELF_BIT = N'(1) << IDX;

	logic               valid_q;
	logic [ID_BITS-1:0] ident_q;
	logic [1:0]         base_q;
	logic [1:0]         level_q;
	logic [7:0]         wait_q;
	logic [15:0]        runtime_q;
	logic [N-1:0]       older_q;
	logic               in_push;

	assign in_push = ctl.push_en & push_vec[IDX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr_valid) begin
			valid_q <= 1'b0;
		end else if (in_push && ctl.kind == PUSH_LOAD) begin
			valid_q <= 1'b1;
		end
	end

	// pushed cells go behind every other cell, keeping their mutual order
	always_ff @(posedge clk) begin
		if (ctl.push_en) begin
			older_q <= (in_push ? (older_q & push_vec) : (older_q | push_vec)) & ~SELF_BIT;
		end
		if (ctl.age_en && valid_q) begin
			if (is_active) begin
				runtime_q <= runtime_q + 16'd1;
			end else if (wait_q != 8'hFF) begin
				wait_q <= wait_q + 8'd1;
			end
		end
		if (in_push) begin
			case (ctl.kind)
				PUSH_PROMOTE: begin
					level_q <= level_q - 2'd1;
					wait_q  <= '0;
				end
				PUSH_LOAD: begin
					ident_q   <= load_id;
					base_q    <= ctl.load_level;
					level_q   <= ctl.load_level;
					wait_q    <= '0;
					runtime_q <= '0;
				end
				PUSH_REQUEUE: begin
					level_q <= base_q;
					wait_q  <= '0;
				end
				default: ;
			endcase
		end
		if (clr_wait) begin
			wait_q <= '0;
		end
	end

	assign valid      = valid_q;
	assign ident      = ident_q;
	assign base_level = base_q;
	assign level      = level_q;
	assign wait_cnt   = wait_q;
	assign older      = older_q;

endmodule
`default_nettype wire

### src/multilevel_priority_job_scheduler_core.sv
// Sequencing: a tick, enqueue or dequeue item runs the six-step sequencer (age, two promotion
//   passes, enqueue/dequeue, pick/switch, result) over the row of slot cells; a finish item
//   goes straight to the result step. A new item is taken only once the result step has
//   handed on the last one, and that step waits while the output is stalled.
// Reset: all slots free, queues empty, no job running, slice counter 1, id counter 0,
//   registers at 10, 1, 2, 5.
`default_nettype none
`include "multilevel_priority_job_scheduler_core_macros.svh"
module multilevel_priority_job_scheduler_core import mlpjs_pkg::*; #(
	parameter int MAX_JOBS = 16,
	parameter int ID_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// priority_req, job_id
	input  logic [((ID_BITS+2+7)/8)*8-1:0]        s_axis_tdata,
	// command
	input  logic [1:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// running_valid, running_id, running_level, switched, assigned_id
	output logic [((2*ID_BITS+4+7)/8)*8-1:0]      m_axis_tdata,
	// status
	output logic [2:0]                            m_axis_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [7:0]                            cfg_data
);

	localparam int N     = MAX_JOBS;
	localparam int SW    = (N > 1) ? $clog2(N) : 1;
	localparam int OUT_W = ((2*ID_BITS+4+7)/8)*8;

	seq_t               state_q;
	cmd_t               cmd_q;
	logic [1:0]         pri_q;
	logic [ID_BITS-1:0] jid_q;
	logic [7:0]         thr_q;
	logic [3:0]         sl0_q, sl1_q, sl2_q;
	logic               present_q, finished_q;
	logic [SW-1:0]      active_q;
	logic [3:0]         slice_q;
	logic               ended_q;
	logic [ID_BITS-1:0] idctr_q;
	status_t            status_q;
	logic [ID_BITS-1:0] assigned_q;
	logic               switched_q;
	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;
	logic [2:0]         m_user_q;

	logic               c_valid [N];
	logic [ID_BITS-1:0] c_ident [N];
	logic [1:0]         c_base  [N];
	logic [1:0]         c_level [N];
	logic [7:0]         c_wait  [N];
	logic [N-1:0]       c_row   [N];
	logic [N-1:0]       col     [N];

	logic [N-1:0] act_oh, member, first_free, pro1, pro2, next_oh, dsel;
	logic [N-1:0] memb_l [3];
	logic [N-1:0] head   [3];
	logic [N-1:0] dm_l   [3];
	logic [N:0]   free_seen;
	logic [N-1:0] push_vec, clr_valid_vec, clr_wait_vec;
	cell_ctl_t    ctl;
	logic [ID_BITS-1:0] load_id;

	logic [ID_BITS-1:0] act_ident;
	logic [1:0]         act_level, pri_eff, lim, next_level, new_level;
	logic               lim_ok, have_next, still, act_hit, d_found, full;
	logic [SW-1:0]      next_idx;
	logic [3:0]         slice_dec, slice_pick, slice_new;
	logic               heads_ok;

	// slot cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		mlpjs_cell #(.N(N), .ID_BITS(ID_BITS), .IDX(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.load_id    (load_id),
			.is_active  (act_oh[i]),
			.push_vec   (push_vec),
			.clr_valid  (clr_valid_vec[i]),
			.clr_wait   (clr_wait_vec[i]),
			.valid      (c_valid[i]),
			.ident      (c_ident[i]),
			.base_level (c_base[i]),
			.level      (c_level[i]),
			.wait_cnt   (c_wait[i]),
			.older      (c_row[i])
		);
		for (genvar j = 0; j < N; j++) begin : g_col
			assign col[i][j] = c_row[j][i];
		end
		assign act_oh[i] = present_q && (active_q == SW'(i));
		assign member[i] = c_valid[i] & ~act_oh[i];
		for (genvar l = 0; l < 3; l++) begin : g_lvl
			assign memb_l[l][i] = member[i] && (c_level[i] == 2'(l));
			assign head[l][i]   = memb_l[l][i] && !(|(memb_l[l] & col[i]));
			assign dm_l[l][i]   = memb_l[l][i] && (c_ident[i] == jid_q);
		end
		// first free slot ripples down the row
		assign first_free[i]  = ~c_valid[i] & ~free_seen[i];
		assign free_seen[i+1] = free_seen[i] | ~c_valid[i];
		assign pro1[i] = memb_l[1][i] && (c_wait[i] >= thr_q);
		assign pro2[i] = memb_l[2][i] && (c_wait[i] >= thr_q);
	end
	assign free_seen[0] = 1'b0;
	assign full         = free_seen[N] == 1'b0 ? 1'b1 : 1'b0;

	assign act_ident = c_ident[active_q];
	assign act_level = c_level[active_q];
	assign act_hit   = present_q && (act_ident == jid_q);
	assign still     = present_q & ~finished_q;
	assign pri_eff   = (pri_q == 2'd3) ? 2'd2 : pri_q;
	assign load_id   = idctr_q + ID_BITS'(1);

	// dequeue target: lowest level first, then queue order
	always_comb begin
		dsel    = '0;
		d_found = 1'b0;
		for (int l = 0; l < 3; l++) begin
			if (!d_found && (|dm_l[l])) begin
				d_found = 1'b1;
				for (int i = 0; i < N; i++) begin
					dsel[i] = dm_l[l][i] && !(|(dm_l[l] & col[i]));
				end
			end
		end
	end

	// next job: head of the best level allowed by the running level
	always_comb begin
		lim       = present_q ? act_level : 2'd2;
		lim_ok    = 1'b1;
		if (!ended_q) begin
			if (lim == 2'd0) begin
				lim_ok = 1'b0;
			end else begin
				lim = lim - 2'd1;
			end
		end
		have_next = 1'b0;
		next_oh   = '0;
		for (int l = 0; l < 3; l++) begin
			if (!have_next && lim_ok && (2'(l) <= lim) && (|memb_l[l])) begin
				have_next = 1'b1;
				next_oh   = head[l];
			end
		end
		next_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (next_oh[i]) begin
				next_idx = next_idx | SW'(i);
			end
		end
	end

	assign next_level = c_level[next_idx];
	assign new_level  = have_next ? next_level : (still ? act_level : 2'd0);

	always_comb begin
		case (new_level)
			2'd1:    slice_pick = sl1_q;
			2'd2:    slice_pick = sl2_q;
			default: slice_pick = sl0_q;
		endcase
		slice_new = (slice_pick == 4'd0) ? 4'd1 : slice_pick;
		slice_dec = ((slice_q == 4'd0) ? 4'd1 : slice_q) - 4'd1;
	end

	// cell controls per sequencer step
	always_comb begin
		ctl           = '0;
		push_vec      = '0;
		clr_valid_vec = '0;
		clr_wait_vec  = '0;
		unique case (state_q)
			SQ_AGE: ctl.age_en = 1'b1;
			SQ_PRO1: begin
				ctl.push_en = 1'b1;
				ctl.kind    = PUSH_PROMOTE;
				push_vec    = pro1;
			end
			SQ_PRO2: begin
				ctl.push_en = 1'b1;
				ctl.kind    = PUSH_PROMOTE;
				push_vec    = pro2;
			end
			SQ_OP: begin
				if (cmd_q == CMD_ENQ && !full) begin
					ctl.push_en    = 1'b1;
					ctl.kind       = PUSH_LOAD;
					ctl.load_level = pri_eff;
					push_vec       = first_free;
				end else if (cmd_q == CMD_DEQ) begin
					clr_valid_vec = act_hit ? act_oh : dsel;
				end
			end
			SQ_PICK: begin
				if (present_q && finished_q) begin
					clr_valid_vec = act_oh;
				end
				if (have_next && still) begin
					ctl.push_en  = 1'b1;
					ctl.kind     = PUSH_REQUEUE;
					push_vec     = act_oh;
					clr_wait_vec = next_oh;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= AGING_RST;
			sl0_q <= SLICE0_RST;
			sl1_q <= SLICE1_RST;
			sl2_q <= SLICE2_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AGING:  thr_q <= cfg_data;
				CFG_SLICE0: sl0_q <= cfg_data[3:0];
				CFG_SLICE1: sl1_q <= cfg_data[3:0];
				CFG_SLICE2: sl2_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_IDLE;
			present_q  <= 1'b0;
			finished_q <= 1'b0;
			active_q   <= '0;
			slice_q    <= 4'd1;
			ended_q    <= 1'b0;
			idctr_q    <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && state_q != SQ_FIN) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				SQ_IDLE: begin
					if (s_axis_tvalid) begin
						if (cmd_t'(s_axis_tuser) == CMD_FINISH) begin
							if (present_q) begin
								finished_q <= 1'b1;
							end
							state_q <= SQ_FIN;
						end else begin
							slice_q <= slice_dec;
							ended_q <= (slice_dec == 4'd0);
							state_q <= SQ_AGE;
						end
					end
				end
				SQ_AGE:  state_q <= SQ_PRO1;
				SQ_PRO1: state_q <= SQ_PRO2;
				SQ_PRO2: state_q <= SQ_OP;
				SQ_OP: begin
					if (cmd_q == CMD_ENQ && !full) begin
						idctr_q <= load_id;
					end else if (cmd_q == CMD_DEQ && act_hit) begin
						present_q  <= 1'b0;
						finished_q <= 1'b0;
					end
					state_q <= SQ_PICK;
				end
				SQ_PICK: begin
					if (have_next) begin
						active_q   <= next_idx;
						present_q  <= 1'b1;
						finished_q <= 1'b0;
					end else if (present_q && finished_q) begin
						present_q  <= 1'b0;
						finished_q <= 1'b0;
					end
					if (ended_q) begin
						slice_q <= slice_new;
					end
					state_q <= SQ_FIN;
				end
				SQ_FIN: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= SQ_IDLE;
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	// item payload and per-item results
	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE && s_axis_tvalid) begin
			cmd_q      <= cmd_t'(s_axis_tuser);
			pri_q      <= s_axis_tdata[1:0];
			jid_q      <= s_axis_tdata[ID_BITS+1:2];
			status_q   <= ST_NONE;
			assigned_q <= '0;
			switched_q <= 1'b0;
		end
		if (state_q == SQ_OP) begin
			if (cmd_q == CMD_ENQ) begin
				if (full) begin
					status_q <= ST_FULL;
				end else begin
					status_q   <= ST_ENQUEUED;
					assigned_q <= load_id;
				end
			end else if (cmd_q == CMD_DEQ) begin
				status_q <= (act_hit || d_found) ? ST_DEQUEUED : ST_NOTFOUND;
			end
		end
		if (state_q == SQ_PICK && have_next) begin
			switched_q <= 1'b1;
		end
		if (state_q == SQ_FIN && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= OUT_W'({assigned_q, switched_q,
				present_q ? act_level : 2'd0,
				present_q ? act_ident : {ID_BITS{1'b0}},
				present_q});
			m_user_q <= status_q;
		end
	end

	assign s_axis_tready = (state_q == SQ_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign cfg_ready     = 1'b1;

	assign heads_ok = $onehot0(head[0]) && $onehot0(head[1]) && $onehot0(head[2]);

	`MLPJS_ASSERT(a_active_slot_valid, clk, arst_n, !present_q || c_valid[active_q], "slot free")
	`MLPJS_ASSERT(a_single_head, clk, arst_n, heads_ok, "queue has more than one head")
	`MLPJS_ASSERT_NEXT(a_id_counter_hold, clk, arst_n, state_q != SQ_OP, $stable(idctr_q), "id")

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the three-level job scheduler core: a self-checking predictor and scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import mlpjs_pkg::*;

	localparam int NSLOT = 16;

	typedef struct {
		bit        run_valid;
		bit [15:0] run_id;
		bit [1:0]  run_level;
		bit        switched;
		bit [15:0] assigned;
		status_t   status;
	} sched_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // priority_req, job_id
	logic [1:0]  s_axis_tuser;  // command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // running_valid, running_id, running_level, switched, assigned_id
	logic [2:0]  m_axis_tuser;  // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	multilevel_priority_job_scheduler_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// scheduler shadow state
	bit        slot_used[NSLOT];
	bit [15:0] slot_id[NSLOT];
	bit [1:0]  slot_base[NSLOT];
	bit [1:0]  slot_lvl[NSLOT];
	bit [7:0]  slot_wait[NSLOT];
	bit [15:0] slot_run[NSLOT];
	int        lvl_q[3][NSLOT];
	int        lvl_n[3];
	bit        cur_present;
	int        cur_slot;
	bit        cur_done;
	int        slice_cnt;
	bit [15:0] id_ctr;
	bit [7:0]  aging_thr;
	bit [3:0]  slice_len[3];

	sched_out_t expected_results[$];
	int errors;
	int items_sent;
	int results_seen;
	int send_gap_max;
	int recv_gap_max;
	int recv_hold;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#10ms;
		$display("[multilevel_priority_job_scheduler_core] ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	function automatic void queue_add(int lvl, int s);
		if (lvl_n[lvl] >= NSLOT)
			return;
		lvl_q[lvl][lvl_n[lvl]] = s;
		lvl_n[lvl]++;
	endfunction

	function automatic void queue_drop(int lvl, int pos);
		for (int k = pos; k + 1 < lvl_n[lvl]; k++)
			lvl_q[lvl][k] = lvl_q[lvl][k + 1];
		lvl_n[lvl]--;
	endfunction

	function automatic void wait_bump(int s);
		if (slot_wait[s] != 8'hff)
			slot_wait[s]++;
	endfunction

	function automatic void age_waiting();
		int kept;
		int s;
		if (cur_present)
			slot_run[cur_slot]++;
		for (int k = 0; k < lvl_n[0]; k++)
			wait_bump(lvl_q[0][k]);
		for (int lvl = 1; lvl <= 2; lvl++) begin
			kept = 0;
			for (int k = 0; k < lvl_n[lvl]; k++) begin
				s = lvl_q[lvl][k];
				wait_bump(s);
				if (slot_wait[s] >= aging_thr) begin
					slot_lvl[s] = 2'(lvl - 1);
					slot_wait[s] = 0;
					queue_add(lvl - 1, s);
				end else begin
					lvl_q[lvl][kept] = s;
					kept++;
				end
			end
			lvl_n[lvl] = kept;
		end
	endfunction

	function automatic status_t admit_job(int pri, output bit [15:0] assigned);
		int s;
		s = 0;
		assigned = 0;
		if (pri > 2)
			pri = 2;
		while (s < NSLOT && slot_used[s])
			s++;
		if (s >= NSLOT)
			return ST_FULL;
		id_ctr++;
		slot_used[s] = 1;
		slot_id[s] = id_ctr;
		slot_base[s] = 2'(pri);
		slot_lvl[s] = 2'(pri);
		slot_wait[s] = 0;
		slot_run[s] = 0;
		queue_add(pri, s);
		assigned = id_ctr;
		return ST_ENQUEUED;
	endfunction

	function automatic status_t remove_job(bit [15:0] id);
		if (cur_present && slot_id[cur_slot] == id) begin
			slot_used[cur_slot] = 0;
			cur_present = 0;
			cur_done = 0;
			return ST_DEQUEUED;
		end
		for (int lvl = 0; lvl <= 2; lvl++)
			for (int k = 0; k < lvl_n[lvl]; k++)
				if (slot_id[lvl_q[lvl][k]] == id) begin
					slot_used[lvl_q[lvl][k]] = 0;
					queue_drop(lvl, k);
					return ST_DEQUEUED;
				end
		return ST_NOTFOUND;
	endfunction

	function automatic sched_out_t sched_predict(cmd_t cmd, int pri, bit [15:0] id);
		sched_out_t r;
		bit ended;
		int lim;
		bit have_next;
		int nxt;
		int c;
		r.switched = 0;
		r.assigned = 0;
		r.status = ST_NONE;
		have_next = 0;
		nxt = 0;
		if (cmd == CMD_FINISH) begin
			if (cur_present)
				cur_done = 1;
		end else begin
			if (slice_cnt == 0)
				slice_cnt = 1;
			slice_cnt--;
			ended = (slice_cnt == 0);
			age_waiting();
			if (cmd == CMD_ENQ)
				r.status = admit_job(pri, r.assigned);
			else if (cmd == CMD_DEQ)
				r.status = remove_job(id);
			lim = cur_present ? slot_lvl[cur_slot] : 2;
			if (lim > 2)
				lim = 2;
			if (!ended)
				lim = (lim == 0) ? 3 : lim - 1;
			for (int lvl = 0; lim <= 2 && lvl <= lim && !have_next; lvl++)
				if (lvl_n[lvl] != 0) begin
					nxt = lvl_q[lvl][0];
					queue_drop(lvl, 0);
					have_next = 1;
				end
			if (cur_present && cur_done) begin
				slot_used[cur_slot] = 0;
				cur_present = 0;
				cur_done = 0;
			end
			if (have_next) begin
				if (cur_present) begin
					c = cur_slot;
					slot_lvl[c] = slot_base[c];
					slot_wait[c] = 0;
					queue_add(slot_base[c], c);
					slot_wait[nxt] = 0;
				end
				cur_slot = nxt;
				cur_present = 1;
				cur_done = 0;
				r.switched = 1;
			end
			if (ended) begin
				slice_cnt = cur_present ? slice_len[slot_lvl[cur_slot]] : slice_len[0];
				if (slice_cnt == 0)
					slice_cnt = 1;
			end
		end
		r.run_valid = cur_present;
		r.run_id = cur_present ? slot_id[cur_slot] : 16'd0;
		r.run_level = cur_present ? slot_lvl[cur_slot] : 2'd0;
		return r;
	endfunction

	task automatic send_item(cmd_t cmd, int pri, bit [15:0] id);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'd0, id, pri[1:0]};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(sched_predict(cmd, pri, id));
		items_sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_AGING: aging_thr = val;
			CFG_SLICE0: slice_len[0] = val[3:0];
			CFG_SLICE1: slice_len[1] = val[3:0];
			default: slice_len[2] = val[3:0];
		endcase
	endtask

	task automatic set_regs(bit [7:0] aging, bit [3:0] s0, bit [3:0] s1, bit [3:0] s2);
		settle();
		write_reg(CFG_AGING, aging);
		write_reg(CFG_SLICE0, {4'd0, s0});
		write_reg(CFG_SLICE1, {4'd0, s1});
		write_reg(CFG_SLICE2, {4'd0, s2});
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [15:0] pick_id();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 16'($urandom);
		if (sel < 4 && cur_present)
			return slot_id[cur_slot];
		return 16'(id_ctr - $urandom_range(0, 20));
	endfunction

	task automatic random_item(int enq_w, int deq_w, int fin_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < enq_w)
			send_item(CMD_ENQ, $urandom_range(0, 3), 16'($urandom));
		else if (r < enq_w + deq_w)
			send_item(CMD_DEQ, $urandom_range(0, 3), pick_id());
		else if (r < enq_w + deq_w + fin_w)
			send_item(CMD_FINISH, $urandom_range(0, 3), 16'($urandom));
		else
			send_item(CMD_TICK, $urandom_range(0, 3), 16'($urandom));
	endtask

	task automatic test_directed();
		send_item(CMD_FINISH, 0, 16'h0000);   // nothing runs, ignored
		send_item(CMD_TICK, 3, 16'hffff);
		send_item(CMD_ENQ, 2, 16'h0000);
		send_item(CMD_ENQ, 1, 16'hffff);
		send_item(CMD_ENQ, 0, 16'h5a5a);
		send_item(CMD_ENQ, 3, 16'ha5a5);      // level three folds to two
		send_item(CMD_ENQ, 2, 16'h0000);
		send_item(CMD_TICK, 0, 16'h0000);
		send_item(CMD_DEQ, 0, 16'hffff);      // unknown id
		send_item(CMD_DEQ, 0, 16'h0000);
		send_item(CMD_DEQ, 0, slot_id[cur_slot]);
		send_item(CMD_DEQ, 0, 16'd4);         // middle of a queue
		send_item(CMD_FINISH, 0, 16'h0000);
		send_item(CMD_FINISH, 0, 16'h0000);
		send_item(CMD_TICK, 0, 16'h0000);
		for (int i = 0; i < 8; i++)
			send_item(CMD_TICK, 0, 16'h0000);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < 18; i++)
			send_item(CMD_ENQ, $urandom_range(0, 3), 16'h0000);
		for (int i = 0; i < 30; i++)
			random_item(20, 10, 10);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 100) begin
				send_gap_max = 0;
				recv_gap_max = 0;
			end else if (i % 200 == 0) begin
				send_gap_max = 6;
				recv_gap_max = 6;
			end
			random_item(30, 25, 10);
		end
	endtask

	task automatic test_backpressure();
		send_gap_max = 0;
		recv_hold = 150;
		for (int i = 0; i < 40; i++)
			random_item(30, 20, 10);
		send_gap_max = 6;
		settle();  // sender pauses until everything has drained
		for (int i = 0; i < 20; i++)
			random_item(30, 20, 10);
	endtask

	// result side: random ready, checks against the oldest expectation
	initial begin
		int stall;
		sched_out_t want;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report("unexpected result", m_axis_tdata, 40'd0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[0] !== want.run_valid)
						report("running_valid", 40'(m_axis_tdata[0]), 40'(want.run_valid));
					if (m_axis_tdata[16:1] !== want.run_id)
						report("running_id", 40'(m_axis_tdata[16:1]), 40'(want.run_id));
					if (m_axis_tdata[18:17] !== want.run_level)
						report("running_level", 40'(m_axis_tdata[18:17]),
							40'(want.run_level));
					if (m_axis_tdata[19] !== want.switched)
						report("switched", 40'(m_axis_tdata[19]), 40'(want.switched));
					if (m_axis_tdata[35:20] !== want.assigned)
						report("assigned_id", 40'(m_axis_tdata[35:20]), 40'(want.assigned));
					if (m_axis_tuser !== want.status)
						report("status", 40'(m_axis_tuser), 40'(want.status));
				end
				stall = $urandom_range(0, recv_gap_max);
			end
			if (recv_hold > 0) begin
				stall = recv_hold;
				recv_hold = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		send_gap_max = 6;
		recv_gap_max = 6;
		recv_hold = 0;
		for (int s = 0; s < NSLOT; s++)
			slot_used[s] = 0;
		lvl_n = '{0, 0, 0};
		cur_present = 0;
		cur_slot = 0;
		cur_done = 0;
		slice_cnt = 1;
		id_ctr = 0;
		aging_thr = AGING_RST;
		slice_len = '{SLICE0_RST, SLICE1_RST, SLICE2_RST};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		set_regs(8'd1, 4'd1, 4'd1, 4'd1);
		test_random(300);
		set_regs(8'd255, 4'd15, 4'd15, 4'd15);
		test_random(400);
		set_regs(8'd3, 4'd2, 4'd4, 4'd8);
		test_backpressure();
		for (int p = 0; p < 4; p++) begin
			set_regs(8'($urandom_range(1, 255)), 4'($urandom_range(1, 15)),
				4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
			test_random(300);
		end
		set_regs(8'd10, 4'd1, 4'd2, 4'd5);
		test_random(100);

		settle();
		$display("covered %0d items and %0d results over eight register settings,", items_sent,
			results_seen);
		$display("including a full job table, back-pressure and aging at both extremes");
		if (errors == 0)
			$display("[multilevel_priority_job_scheduler_core] OK");
		else
			$display("[multilevel_priority_job_scheduler_core] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
